// ===== rtl/hmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// hmtf_pkg
// Shared types and constants of the hysteresis mid-tracking filter.
// ----------------------------------------------------------------------------
package hmtf_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BAND_W = 15;
  localparam int LIMIT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HYST_BAND = 3'd0,
    REG_LOW_LIMIT = 3'd1,
    REG_HIGH_LIMIT = 3'd2,
    REG_MID_STEP = 3'd3
  } reg_idx_t;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_RESET = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctrl_t;

endpackage

// ===== rtl/hmtf_if.sv =====
// ----------------------------------------------------------------------------
// hmtf_if
// Valid/ready channels of the filter: config writes, input and result words.
// ----------------------------------------------------------------------------
interface hmtf_cfg_if
  import hmtf_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface hmtf_in_if
  import hmtf_pkg::*;
  #(parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF) ();
  logic valid;
  logic ready;
  logic opcode;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source(output valid, opcode, sample, input ready);
  modport sink(input valid, opcode, sample, output ready);
endinterface

interface hmtf_out_if
  import hmtf_pkg::*;
  #(parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF) ();
  logic valid;
  logic ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;

  modport source(output valid, filtered, input ready);
  modport sink(input valid, filtered, output ready);
endinterface

// ===== rtl/hmtf_cell.sv =====
// ----------------------------------------------------------------------------
// hmtf_cell
// One window entry with a running min/max stage fed from its neighbor.
// ----------------------------------------------------------------------------
module hmtf_cell
  import hmtf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cell_ctrl_t                     ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] fill_value,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_in,
  input  logic signed [SAMPLE_WIDTH-1:0] lo_in,
  input  logic signed [SAMPLE_WIDTH-1:0] hi_in,
  output logic signed [SAMPLE_WIDTH-1:0] entry,
  output logic signed [SAMPLE_WIDTH-1:0] lo,
  output logic signed [SAMPLE_WIDTH-1:0] hi
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctl.fill) begin
      entry <= fill_value;
    end else if (ctl.shift) begin
      entry <= shift_in;
    end
  end

  // fold own entry into the partial min/max from the previous cell
  always_ff @(posedge clk) begin
    lo <= (entry < lo_in) ? entry : lo_in;
    hi <= (entry > hi_in) ? entry : hi_in;
  end

endmodule

// ===== rtl/hysteresis_mid_tracking_filter.sv =====
// ----------------------------------------------------------------------------
// hysteresis_mid_tracking_filter
// Backlash filter with drift toward the midpoint of a sliding sample window.
// ----------------------------------------------------------------------------
// A filter word is accepted, the SCAN state waits out the min/max walk down the cell row,
// then the result register is loaded and passed on to the output register from DONE;
// a reset word goes from acceptance straight to DONE. A new word is taken only in IDLE,
// after the last result has been loaded into the output register; a stalled result word
// holds the input off.
// Reset: output valid, window and limits return to their defaults.
module hysteresis_mid_tracking_filter
  import hmtf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hmtf_cfg_if.sink   cfg,
  hmtf_in_if.sink    data_in,
  hmtf_out_if.source data_out
);

  localparam int EW = ((SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W) + 2;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH);

  logic [BAND_W-1:0]         hyst_band;
  logic signed [LIMIT_W-1:0] lower_lim;
  logic signed [LIMIT_W-1:0] upper_lim;
  logic [BAND_W-1:0]         drift_step;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  logic signed [SAMPLE_WIDTH-1:0] held;
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [SAMPLE_WIDTH-1:0] y_band;
  logic signed [SAMPLE_WIDTH-1:0] result;

  logic in_fire, out_load;
  cell_ctrl_t ctl;

  logic signed [EW-1:0] xe, ye, he, loe, hie, y1;
  logic signed [EW-1:0] xr, yb, se, mid, y2;

  logic signed [SAMPLE_WIDTH-1:0] entry [WINDOW_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] lo_q  [WINDOW_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] hi_q  [WINDOW_DEPTH];

  // config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_band <= '0;
      lower_lim <= {1'b1, {(LIMIT_W-1){1'b0}}};
      upper_lim <= {1'b0, {(LIMIT_W-1){1'b1}}};
      drift_step <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HYST_BAND:  hyst_band <= cfg.data[BAND_W-1:0];
        REG_LOW_LIMIT:  lower_lim <= $signed(cfg.data[LIMIT_W-1:0]);
        REG_HIGH_LIMIT: upper_lim <= $signed(cfg.data[LIMIT_W-1:0]);
        REG_MID_STEP:   drift_step <= cfg.data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // cell row
  assign in_fire = data_in.valid && data_in.ready;
  assign ctl = {in_fire && (data_in.opcode == OP_FILTER),
                in_fire && (data_in.opcode == OP_RESET)};

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      hmtf_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .fill_value(data_in.sample), .shift_in(data_in.sample),
        .lo_in(entry[0]), .hi_in(entry[0]),
        .entry(entry[0]), .lo(lo_q[0]), .hi(hi_q[0])
      );
    end else begin : g_body
      hmtf_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .fill_value(data_in.sample), .shift_in(entry[i-1]),
        .lo_in(lo_q[i-1]), .hi_in(hi_q[i-1]),
        .entry(entry[i]), .lo(lo_q[i]), .hi(hi_q[i])
      );
    end
  end

  // band step
  assign xe = EW'(data_in.sample);
  assign ye = EW'(held);
  assign he = EW'($signed({1'b0, hyst_band}));
  assign loe = EW'(lower_lim);
  assign hie = EW'(upper_lim);

  always_comb begin
    if (xe > ye && xe >= hie) begin
      y1 = xe;
    end else if (xe < ye && xe <= loe) begin
      y1 = xe;
    end else if (xe > ye + he) begin
      y1 = xe - he;
    end else if (xe < ye - he) begin
      y1 = xe + he;
    end else begin
      y1 = ye;
    end
  end

  // midpoint drift
  assign xr = EW'(x_reg);
  assign yb = EW'(y_band);
  assign se = EW'($signed({1'b0, drift_step}));
  assign mid = EW'(lo_q[WINDOW_DEPTH-1])
             + ((EW'(hi_q[WINDOW_DEPTH-1]) - EW'(lo_q[WINDOW_DEPTH-1])) >>> 1);

  always_comb begin
    if (yb > mid && xr < yb) begin
      y2 = (yb - se > mid) ? yb - se : mid;
    end else if (yb < mid && xr > yb) begin
      y2 = (yb + se < mid) ? yb + se : mid;
    end else begin
      y2 = yb;
    end
  end

  // control
  assign data_in.ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!data_out.valid || data_out.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (data_in.opcode == OP_RESET) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_fire) begin
      cnt <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.fill) begin
      held <= data_in.sample;
    end else if (state == ST_SCAN && cnt == CNT_LAST) begin
      held <= y2[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      x_reg <= data_in.sample;
      y_band <= y1[SAMPLE_WIDTH-1:0];
    end
    if (ctl.fill) begin
      result <= data_in.sample;
    end else if (state == ST_SCAN && cnt == CNT_LAST) begin
      result <= y2[SAMPLE_WIDTH-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_out.valid <= 1'b0;
    end else if (out_load) begin
      data_out.valid <= 1'b1;
    end else if (data_out.ready) begin
      data_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_out.filtered <= result;
    end
  end

endmodule
